/* hw/rtl/assert_macros.svh */
// assertion macros shared by the sorted key table rtl
// expects signals named clock and reset in the including module
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property that holds on every edge outside reset
`define SKT_ASSERT(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (prop)) \
      else $error(msg);

// same-cycle implication
`define SKT_ASSERT_IMPLY(label, pre, post, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (pre) |-> (post)) \
      else $error(msg);

// next-cycle implication
`define SKT_ASSERT_NEXT(label, pre, post, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (pre) |=> (post)) \
      else $error(msg);

`endif

/* hw/rtl/sktsd_pkg.sv */
// types and codes for the sorted key table search and delete block
// used by sktsd_store, sktsd_ctrl and the top level; no dependencies
package sktsd_pkg;

   localparam int REQ_W  = 2;
   localparam int KEY_W  = 63;
   localparam int PAY_W  = 32;
   localparam int STAT_W = 2;
   localparam int POS_W  = 10;

   // request codes
   localparam logic [REQ_W-1:0] REQ_APPEND = 2'd0;
   localparam logic [REQ_W-1:0] REQ_LOOKUP = 2'd1;
   localparam logic [REQ_W-1:0] REQ_DELETE = 2'd2;

   // result status codes
   localparam logic [STAT_W-1:0] STAT_OK    = 2'd0;
   localparam logic [STAT_W-1:0] STAT_MISS  = 2'd1;
   localparam logic [STAT_W-1:0] STAT_FULL  = 2'd2;
   localparam logic [STAT_W-1:0] STAT_ORDER = 2'd3;

   typedef struct packed {
      logic [REQ_W-1:0] req_type;
      logic [KEY_W-1:0] key;
      logic [PAY_W-1:0] payload_in;
   } req_beat_type;

   typedef struct packed {
      logic [STAT_W-1:0] status;
      logic [POS_W-1:0]  position;
      logic [PAY_W-1:0]  payload_out;
   } rsp_beat_type;

   // memory strobes from the sequencer
   typedef struct packed {
      logic rd_en;
      logic entry_we;
      logic act_we;
      logic act_wdata;
   } store_ctl_type;

   typedef enum logic [1:0] {
      S_IDLE,
      S_SEARCH,
      S_COMPARE,
      S_APP_CHECK
   } ctrl_state_type;

endpackage

/* hw/rtl/sktsd_store.sv */
// key, payload and active mark memories of the sorted key table
// one shared address, one write and one registered read per cycle; uses sktsd_pkg
module sktsd_store
   import sktsd_pkg::*;
#(
   parameter int TABLE_DEPTH = 1024,
   localparam int AW = $clog2(TABLE_DEPTH)
) (
   input  logic             clock,
   input  store_ctl_type    ctl,
   input  logic [AW-1:0]    addr,
   input  logic [KEY_W-1:0] wr_key,
   input  logic [PAY_W-1:0] wr_pay,
   output logic [KEY_W-1:0] rd_key,
   output logic [PAY_W-1:0] rd_pay,
   output logic             rd_act
);

   logic [KEY_W-1:0] key_mem [TABLE_DEPTH];
   logic [PAY_W-1:0] pay_mem [TABLE_DEPTH];
   logic             act_mem [TABLE_DEPTH];

   logic [KEY_W-1:0] rd_key_ff;
   logic [PAY_W-1:0] rd_pay_ff;
   logic             rd_act_ff;

   always_ff @(posedge clock) begin
      if (ctl.entry_we) begin
         key_mem[addr] <= wr_key;
         pay_mem[addr] <= wr_pay;
      end
      if (ctl.act_we) begin
         act_mem[addr] <= ctl.act_wdata;
      end
      if (ctl.rd_en) begin
         rd_key_ff <= key_mem[addr];
         rd_pay_ff <= pay_mem[addr];
         rd_act_ff <= act_mem[addr];
      end
   end

   assign rd_key = rd_key_ff;
   assign rd_pay = rd_pay_ff;
   assign rd_act = rd_act_ff;

endmodule

/* hw/rtl/sktsd_ctrl.sv */
// sequencer of the sorted key table: append check, binary search probes,
// logical delete and entry count; uses sktsd_pkg and assert_macros.svh
`include "assert_macros.svh"

module sktsd_ctrl
   import sktsd_pkg::*;
#(
   parameter int TABLE_DEPTH = 1024,
   localparam int AW = $clog2(TABLE_DEPTH),
   localparam int CW = $clog2(TABLE_DEPTH + 1)
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   input  req_beat_type     req_beat,
   output logic             busy,
   output store_ctl_type    ctl,
   output logic [AW-1:0]    addr,
   output logic [KEY_W-1:0] wr_key,
   output logic [PAY_W-1:0] wr_pay,
   input  logic [KEY_W-1:0] rd_key,
   input  logic [PAY_W-1:0] rd_pay,
   input  logic             rd_act,
   output logic             done,
   output rsp_beat_type     result
);

   ctrl_state_type state_ff, state_in;
   req_beat_type   req_ff, req_in;
   logic [CW-1:0]  count_ff, count_in;
   logic [CW-1:0]  lo_ff, lo_in;
   logic [CW-1:0]  hi_ff, hi_in;
   logic [AW-1:0]  mid_ff, mid_in;
   logic [CW-1:0]  mid_w;

   assign mid_w = lo_ff + ((hi_ff - lo_ff) >> 1);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         count_ff <= '0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
      end
      req_ff <= req_in;
      lo_ff  <= lo_in;
      hi_ff  <= hi_in;
      mid_ff <= mid_in;
   end

   always_comb begin
      state_in       = state_ff;
      req_in         = req_ff;
      count_in       = count_ff;
      lo_in          = lo_ff;
      hi_in          = hi_ff;
      mid_in         = mid_ff;
      ctl            = '0;
      addr           = '0;
      done           = 1'b0;
      result         = '0;
      result.status  = STAT_MISS;
      unique case (state_ff)
         S_IDLE: begin
            if (start) begin
               req_in = req_beat;
               case (req_beat.req_type) inside
                  REQ_APPEND: begin
                     if (count_ff >= CW'(TABLE_DEPTH)) begin
                        done          = 1'b1;
                        result.status = STAT_FULL;
                     end else begin
                        state_in = S_APP_CHECK;
                        if (count_ff != '0) begin
                           ctl.rd_en = 1'b1;
                           addr      = AW'(count_ff - CW'(1));
                        end
                     end
                  end
                  REQ_LOOKUP, REQ_DELETE: begin
                     lo_in    = '0;
                     hi_in    = count_ff;
                     state_in = S_SEARCH;
                  end
                  default: begin
                     done = 1'b1;
                  end
               endcase
            end
         end
         S_SEARCH: begin
            if (lo_ff < hi_ff) begin
               ctl.rd_en = 1'b1;
               addr      = AW'(mid_w);
               mid_in    = AW'(mid_w);
               state_in  = S_COMPARE;
            end else begin
               done     = 1'b1;
               state_in = S_IDLE;
            end
         end
         S_COMPARE: begin
            addr = mid_ff;
            if (rd_key == req_ff.key) begin
               done     = 1'b1;
               state_in = S_IDLE;
               if (rd_act) begin
                  result.status   = STAT_OK;
                  result.position = POS_W'(mid_ff);
                  if (req_ff.req_type == REQ_DELETE) begin
                     ctl.act_we    = 1'b1;
                     ctl.act_wdata = 1'b0;
                  end else begin
                     result.payload_out = rd_pay;
                  end
               end
            end else if (rd_key < req_ff.key) begin
               lo_in    = CW'(mid_ff) + CW'(1);
               state_in = S_SEARCH;
            end else begin
               hi_in    = CW'(mid_ff);
               state_in = S_SEARCH;
            end
         end
         S_APP_CHECK: begin
            addr     = AW'(count_ff);
            done     = 1'b1;
            state_in = S_IDLE;
            if (count_ff != '0 && req_ff.key <= rd_key) begin
               result.status = STAT_ORDER;
            end else begin
               ctl.entry_we    = 1'b1;
               ctl.act_we      = 1'b1;
               ctl.act_wdata   = 1'b1;
               count_in        = count_ff + CW'(1);
               result.status   = STAT_OK;
               result.position = POS_W'(count_ff);
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   assign busy   = (state_ff != S_IDLE);
   assign wr_key = req_ff.key;
   assign wr_pay = req_ff.payload_in;

   `SKT_ASSERT(a_count_range, count_ff <= CW'(TABLE_DEPTH), "entry count above table depth")
   `SKT_ASSERT_IMPLY(a_probe_window, state_ff == S_COMPARE, (CW'(mid_ff) >= lo_ff) && (CW'(mid_ff) < hi_ff), "probe outside search window")
   `SKT_ASSERT_NEXT(a_done_idle, done, state_ff == S_IDLE, "sequencer busy after result")
   `SKT_ASSERT_IMPLY(a_count_step, !$past(reset) && (count_ff != $past(count_ff)), count_ff == CW'($past(count_ff) + CW'(1)), "entry count moved by other than one")

endmodule

/* hw/rtl/sorted_key_table_search_delete_top.sv */
// sorted key table with append, binary search lookup and logical delete
// command channel in, strobed result beat out; uses sktsd_pkg,
// sktsd_store and sktsd_ctrl
//
// usage:
//   a request beat (req_beat) is taken at a rising edge with start high
//   and busy low. req_type selects append, lookup or delete.
//   every request gives exactly one result beat on rsp_beat, shown for
//   one cycle with rsp_valid high; the receiver cannot hold it off.
// timing:
//   append: the last key is read, then busy while it is checked and the
//   entry written; result strobe in the cycle after.
//   lookup or delete: each probe is a key memory read, then a compare;
//   a search that ends with an empty window adds a final window check.
//   with n entries a search makes at most ceil(log2(n + 1)) probes, and
//   the result strobe follows in the cycle after the final compare or check.
//   unused request code and full table: result strobe in the next cycle.
//   the next request may start in the cycle the strobe is shown.
// reset:
//   synchronous; clears the entry count and the sequencer, memories are
//   not cleared and need no clearing pass (only filled entries are read).
module sorted_key_table_search_delete_top
   import sktsd_pkg::*;
#(
   parameter int TABLE_DEPTH = 1024
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         start,
   input  req_beat_type req_beat,
   output logic         busy,
   output logic         rsp_valid,
   output rsp_beat_type rsp_beat
);

   localparam int AW = $clog2(TABLE_DEPTH);

   store_ctl_type    ctl;
   logic [AW-1:0]    addr;
   logic [KEY_W-1:0] wr_key;
   logic [PAY_W-1:0] wr_pay;
   logic [KEY_W-1:0] rd_key;
   logic [PAY_W-1:0] rd_pay;
   logic             rd_act;
   logic             done;
   rsp_beat_type     result;

   logic             rsp_valid_ff;
   rsp_beat_type     rsp_beat_ff;

   sktsd_ctrl #(
      .TABLE_DEPTH(TABLE_DEPTH)
   ) u_ctrl (
      .clock    (clock),
      .reset    (reset),
      .start    (start),
      .req_beat (req_beat),
      .busy     (busy),
      .ctl      (ctl),
      .addr     (addr),
      .wr_key   (wr_key),
      .wr_pay   (wr_pay),
      .rd_key   (rd_key),
      .rd_pay   (rd_pay),
      .rd_act   (rd_act),
      .done     (done),
      .result   (result)
   );

   sktsd_store #(
      .TABLE_DEPTH(TABLE_DEPTH)
   ) u_store (
      .clock  (clock),
      .ctl    (ctl),
      .addr   (addr),
      .wr_key (wr_key),
      .wr_pay (wr_pay),
      .rd_key (rd_key),
      .rd_pay (rd_pay),
      .rd_act (rd_act)
   );

   // result beat register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= done;
      end
      if (done) begin
         rsp_beat_ff <= result;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_beat  = rsp_beat_ff;

endmodule
